/* design/lj_pkg.sv */
// Shared types and constants for the Lennard-Jones pair force accumulator.
// No dependencies; imported by every module of the block.
`default_nettype none
package lj_pkg;

	// Widths of the sums, the capped magnitudes and the shared multiplier
	localparam int SUM_W  = 48;
	localparam int MAG_W  = 47;
	localparam int MUL_W  = 64;
	localparam int PROD_W = 2 * MUL_W;
	localparam int LIMB_W = MUL_W / 2;
	localparam int CUT_W  = 32;
	localparam int DMAG_W = 32;

	localparam logic [MAG_W-1:0] MAG_CAP = {MAG_W{1'b1}};
	localparam logic [63:0] D_CLAMP = 64'd1 << 31;

	// Multiplier operation codes, issued in this order
	typedef logic [3:0] op_t;
	localparam op_t OP_SQ_X = 4'd0;
	localparam op_t OP_SQ_Y = 4'd1;
	localparam op_t OP_SQ_Z = 4'd2;
	localparam op_t OP_INV2 = 4'd3;
	localparam op_t OP_INV3 = 4'd4;
	localparam op_t OP_INV4 = 4'd5;
	localparam op_t OP_INV6 = 4'd6;
	localparam op_t OP_CMAG = 4'd7;
	localparam op_t OP_TX   = 4'd8;
	localparam op_t OP_TY   = 4'd9;
	localparam op_t OP_TZ   = 4'd10;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic mul_start;
		op_t  op;
		logic div_start;
		logic flag_zero;
		logic commit;
		logic emit;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic mul_done;
		logic div_done;
		logic zero_dist;
		logic in_cut;
		logic last;
	} stat_t;

endpackage
`default_nettype wire

/* design/lennard_jones_force_accumulator_core.sv */
// Lennard-Jones pair force accumulator core: one pair per input transaction,
// accumulated force and energy sums out on a last pair.
// Input channel: in_valid/in_ready with own_* and other_* positions (signed
// Q8.16 by default), first (clear sums before this pair) and last (emit after).
// Output channel: out_valid/out_ready with acc_x/y/z, potential_energy (Q32.16)
// and saturated. Only a transaction with last produces an output transaction.
// Configuration channel: cfg_valid/cfg_ready/cfg_data writes cutoff_sq; it is
// always ready, and the user must see that it is written only while the core
// is idle; the core itself does not enforce this. One pair is in flight at a
// time, on a shared 64x64 multiplier built on one 32x32 partial product and a
// one-bit-per-cycle divider. A pair beyond the cutoff or at zero distance
// stops after the squares; one inside it also runs the divider and multiplies.
// The output register lets the next pair start while a result waits; a last
// pair that finds the register still full holds until the receiver takes it.
// Reset clears the sums and the flag and sets cutoff_sq to 16.0.
`default_nettype none
module lennard_jones_force_accumulator_core #(
	parameter int FRAC_BITS = 16,
	parameter int POS_WIDTH = 24
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_valid,
	output logic                           cfg_ready,
	input  wire [lj_pkg::CUT_W-1:0]        cfg_data,
	input  wire                            in_valid,
	output logic                           in_ready,
	input  wire signed [POS_WIDTH-1:0]     own_x,
	input  wire signed [POS_WIDTH-1:0]     own_y,
	input  wire signed [POS_WIDTH-1:0]     own_z,
	input  wire signed [POS_WIDTH-1:0]     other_x,
	input  wire signed [POS_WIDTH-1:0]     other_y,
	input  wire signed [POS_WIDTH-1:0]     other_z,
	input  wire                            first,
	input  wire                            last,
	output logic                           out_valid,
	input  wire                            out_ready,
	output logic signed [lj_pkg::SUM_W-1:0] acc_x,
	output logic signed [lj_pkg::SUM_W-1:0] acc_y,
	output logic signed [lj_pkg::SUM_W-1:0] acc_z,
	output logic signed [lj_pkg::SUM_W-1:0] potential_energy,
	output logic                           saturated
);
	import lj_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	lj_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	lj_dp #(.FRAC_BITS(FRAC_BITS), .POS_WIDTH(POS_WIDTH)) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_valid),
		.cfg_data         (cfg_data),
		.own_x            (own_x),
		.own_y            (own_y),
		.own_z            (own_z),
		.other_x          (other_x),
		.other_y          (other_y),
		.other_z          (other_z),
		.first            (first),
		.last             (last),
		.cmd              (cmd),
		.stat             (stat),
		.acc_x            (acc_x),
		.acc_y            (acc_y),
		.acc_z            (acc_z),
		.potential_energy (potential_energy),
		.saturated        (saturated)
	);
endmodule
`default_nettype wire

/* design/lj_mul.sv */
// Multi-cycle 64x64 unsigned multiplier built on one 32x32 partial product.
// Uses lj_pkg for widths; four partial products, registered, then accumulated.
`default_nettype none
module lj_mul (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       start,
	input  wire [lj_pkg::MUL_W-1:0]   a,
	input  wire [lj_pkg::MUL_W-1:0]   b,
	output logic                      done,
	output logic [lj_pkg::PROD_W-1:0] prod
);
	import lj_pkg::*;

	logic [MUL_W-1:0]    a_q, b_q;
	logic [2:0]          cnt_q;
	logic                busy_q, done_q;
	logic [MUL_W-1:0]    p_s1;
	logic [1:0]          sh_s1;
	logic [PROD_W-1:0]   acc_q;
	logic [LIMB_W-1:0]   a_limb, b_limb;
	logic [PROD_W-1:0]   p_ext;

	// Pick limbs for the current step
	assign a_limb = cnt_q[1] ? a_q[MUL_W-1:LIMB_W] : a_q[LIMB_W-1:0];
	assign b_limb = cnt_q[0] ? b_q[MUL_W-1:LIMB_W] : b_q[LIMB_W-1:0];

	// Align the registered partial product
	always_comb begin
		case (sh_s1)
			2'd0:    p_ext = PROD_W'(p_s1);
			2'd1:    p_ext = PROD_W'(p_s1) << LIMB_W;
			default: p_ext = PROD_W'(p_s1) << (2 * LIMB_W);
		endcase
	end

	// Control: step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: partial product stage and accumulator
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q != 3'd4) begin
				p_s1  <= a_limb * b_limb;
				sh_s1 <= {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
			end
			if (cnt_q != 3'd0)
				acc_q <= acc_q + p_ext;
		end
	end

	assign done = done_q;
	assign prod = acc_q;
endmodule
`default_nettype wire

/* design/lj_div.sv */
// Restoring divider forming floor(2^(2*FRAC_BITS) / divisor), one bit a cycle.
// Uses lj_pkg for the divisor width.
`default_nettype none
module lj_div #(
	parameter int FRAC_BITS = 16
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      start,
	input  wire [lj_pkg::CUT_W-1:0]  divisor,
	output logic                     done,
	output logic [2*FRAC_BITS:0]     quot
);
	import lj_pkg::*;

	localparam int QW  = 2 * FRAC_BITS + 1;
	localparam int CW  = $clog2(QW);

	logic [CUT_W-1:0] rem_q;
	logic [QW-1:0]    quot_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q, done_q;
	logic [CUT_W:0]   trial;
	logic             fits;

	// The dividend holds a single one at its top bit
	assign trial = {rem_q, (cnt_q == '0)};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift in one quotient bit per step
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? CUT_W'(trial - {1'b0, divisor}) : trial[CUT_W-1:0];
			quot_q <= {quot_q[QW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quot_q;
endmodule
`default_nettype wire

/* design/lj_ctrl.sv */
// Controller state machine sequencing the shared divider and multiplier.
// Uses lj_pkg for command and status structs and operation codes.
`default_nettype none
module lj_ctrl (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  wire            out_ready,
	input  lj_pkg::stat_t  stat,
	output lj_pkg::cmd_t   cmd
);
	import lj_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_MSTART = 3'd1;
	localparam logic [2:0] ST_MWAIT  = 3'd2;
	localparam logic [2:0] ST_CHECK  = 3'd3;
	localparam logic [2:0] ST_DSTART = 3'd4;
	localparam logic [2:0] ST_DWAIT  = 3'd5;
	localparam logic [2:0] ST_COMMIT = 3'd6;
	localparam logic [2:0] ST_FINISH = 3'd7;

	logic [2:0] state_q, state_d;
	op_t        op_q, op_d;
	logic       out_valid_q;
	logic       emit;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign emit = (state_q == ST_FINISH) && stat.last && (!out_valid_q || out_ready);

	// Next state and commands
	always_comb begin
		state_d       = state_q;
		op_d          = op_q;
		cmd           = '0;
		cmd.op        = op_q;
		cmd.emit      = emit;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					op_d     = OP_SQ_X;
					state_d  = ST_MSTART;
				end
			end
			ST_MSTART: begin
				cmd.mul_start = 1'b1;
				state_d       = ST_MWAIT;
			end
			ST_MWAIT: begin
				if (stat.mul_done) begin
					if (op_q == OP_SQ_Z) state_d = ST_CHECK;
					else if (op_q == OP_TZ) state_d = ST_COMMIT;
					else begin
						op_d    = op_q + 4'd1;
						state_d = ST_MSTART;
					end
				end
			end
			ST_CHECK: begin
				if (stat.zero_dist) begin
					cmd.flag_zero = 1'b1;
					state_d       = ST_FINISH;
				end else if (stat.in_cut) state_d = ST_DSTART;
				else state_d = ST_FINISH;
			end
			ST_DSTART: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DWAIT;
			end
			ST_DWAIT: begin
				if (stat.div_done) begin
					op_d    = OP_INV2;
					state_d = ST_MSTART;
				end
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = ST_FINISH;
			end
			ST_FINISH: begin
				if (!stat.last || emit) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Hold state, operation and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_SQ_X;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			if (emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end
endmodule
`default_nettype wire

/* design/lj_dp.sv */
// Datapath: distances, inverse powers, force terms, saturating sums, result register.
// Uses lj_pkg; instantiates lj_mul and lj_div.
`default_nettype none
module lj_dp #(
	parameter int FRAC_BITS = 16,
	parameter int POS_WIDTH = 24
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_we,
	input  wire [lj_pkg::CUT_W-1:0]      cfg_data,
	input  wire signed [POS_WIDTH-1:0]   own_x,
	input  wire signed [POS_WIDTH-1:0]   own_y,
	input  wire signed [POS_WIDTH-1:0]   own_z,
	input  wire signed [POS_WIDTH-1:0]   other_x,
	input  wire signed [POS_WIDTH-1:0]   other_y,
	input  wire signed [POS_WIDTH-1:0]   other_z,
	input  wire                          first,
	input  wire                          last,
	input  lj_pkg::cmd_t                 cmd,
	output lj_pkg::stat_t                stat,
	output logic signed [lj_pkg::SUM_W-1:0] acc_x,
	output logic signed [lj_pkg::SUM_W-1:0] acc_y,
	output logic signed [lj_pkg::SUM_W-1:0] acc_z,
	output logic signed [lj_pkg::SUM_W-1:0] potential_energy,
	output logic                          saturated
);
	import lj_pkg::*;

	localparam int DW = POS_WIDTH + 1;
	localparam int QW = 2 * FRAC_BITS + 1;
	localparam int TW = MAG_W + 8;
	localparam logic [CUT_W-1:0] CUT_RST = CUT_W'(16) << FRAC_BITS;
	localparam logic signed [SUM_W:0] S_MAX = (SUM_W+1)'({1'b0, {(SUM_W-1){1'b1}}});
	localparam logic signed [SUM_W:0] S_MIN = -S_MAX - (SUM_W+1)'(1);
	localparam logic signed [SUM_W+1:0] E_MAX = (SUM_W+2)'(S_MAX);
	localparam logic signed [SUM_W+1:0] E_MIN = (SUM_W+2)'(S_MIN);

	logic [CUT_W-1:0]  cutoff_q;
	logic [DMAG_W-1:0] mag_q [3];
	logic [2:0]        neg_q;
	logic              last_q, sat_q;
	logic [63:0]       r2_q, r2_sh;
	logic [MAG_W-1:0]  inv_q, inv2_q, inv3_q, inv4_q, inv6_q, cmag_q;
	logic [MAG_W-1:0]  term_q [3];
	logic signed [SUM_W-1:0] sum_q [3];
	logic signed [SUM_W-1:0] sum_e_q;
	logic              sticky_q;

	logic [MUL_W-1:0]  mul_a, mul_b;
	logic              mul_done, div_done;
	logic [PROD_W-1:0] prod, prod_sh;
	logic [MAG_W-1:0]  fm;
	logic              fm_ovf;
	logic [QW-1:0]     quot;

	logic signed [TW-1:0] t48, tval;
	logic              cneg;
	logic [TW-1:0]     tmag;

	logic signed [DW-1:0] d [3];
	logic [DW-1:0]     dabs [3];
	logic [63:0]       dabs64 [3];
	logic [DMAG_W-1:0] dmag [3];

	logic signed [SUM_W:0]   tsum [3];
	logic signed [SUM_W-1:0] tnew [3];
	logic [2:0]              tclamp;
	logic signed [SUM_W+1:0] ediff;
	logic signed [SUM_W-1:0] eterm;
	logic                    eclamp;
	logic signed [SUM_W:0]   esum;
	logic signed [SUM_W-1:0] enew;
	logic                    esclamp;
	logic signed [SUM_W-1:0] sterm [3];

	// Difference vector magnitudes, clamped for very distant pairs
	assign d[0] = DW'(own_x) - DW'(other_x);
	assign d[1] = DW'(own_y) - DW'(other_y);
	assign d[2] = DW'(own_z) - DW'(other_z);
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			dabs[k]   = d[k][DW-1] ? DW'(-d[k]) : DW'(d[k]);
			dabs64[k] = 64'(dabs[k]);
			dmag[k]   = (dabs64[k] > D_CLAMP) ? D_CLAMP[DMAG_W-1:0] : dabs64[k][DMAG_W-1:0];
		end
	end

	// Squared distance status
	assign r2_sh = r2_q >> FRAC_BITS;
	assign stat.zero_dist = (r2_sh == 64'd0);
	assign stat.in_cut    = (r2_sh < 64'(cutoff_q));
	assign stat.last      = last_q;
	assign stat.mul_done  = mul_done;
	assign stat.div_done  = div_done;

	// t = 48*inv3 - 24*one and its magnitude
	assign t48  = TW'({inv3_q, 5'd0}) + TW'({inv3_q, 4'd0});
	assign tval = t48 - (TW'(24) << FRAC_BITS);
	assign cneg = tval[TW-1];
	assign tmag = cneg ? TW'(-tval) : TW'(tval);

	// Operand selection for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_SQ_X: begin mul_a = MUL_W'(mag_q[0]); mul_b = MUL_W'(mag_q[0]); end
			OP_SQ_Y: begin mul_a = MUL_W'(mag_q[1]); mul_b = MUL_W'(mag_q[1]); end
			OP_SQ_Z: begin mul_a = MUL_W'(mag_q[2]); mul_b = MUL_W'(mag_q[2]); end
			OP_INV2: begin mul_a = MUL_W'(inv_q);    mul_b = MUL_W'(inv_q); end
			OP_INV3: begin mul_a = MUL_W'(inv2_q);   mul_b = MUL_W'(inv_q); end
			OP_INV4: begin mul_a = MUL_W'(inv3_q);   mul_b = MUL_W'(inv_q); end
			OP_INV6: begin mul_a = MUL_W'(inv3_q);   mul_b = MUL_W'(inv3_q); end
			OP_CMAG: begin mul_a = MUL_W'(inv4_q);   mul_b = MUL_W'(tmag); end
			OP_TX:   begin mul_a = MUL_W'(mag_q[0]); mul_b = MUL_W'(cmag_q); end
			OP_TY:   begin mul_a = MUL_W'(mag_q[1]); mul_b = MUL_W'(cmag_q); end
			OP_TZ:   begin mul_a = MUL_W'(mag_q[2]); mul_b = MUL_W'(cmag_q); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	lj_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (prod)
	);

	lj_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.divisor (r2_sh[CUT_W-1:0]),
		.done    (div_done),
		.quot    (quot)
	);

	// Fixed-point product: drop fraction bits, cap the magnitude
	assign prod_sh = prod >> FRAC_BITS;
	assign fm_ovf  = |prod_sh[PROD_W-1:MAG_W];
	assign fm      = fm_ovf ? MAG_CAP : prod_sh[MAG_W-1:0];

	// Sum updates with clamping
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sterm[k] = (neg_q[k] != cneg) ? -SUM_W'(term_q[k]) : SUM_W'(term_q[k]);
			tsum[k]  = (SUM_W+1)'(sum_q[k]) + (SUM_W+1)'(sterm[k]);
			tclamp[k] = (tsum[k] > S_MAX) || (tsum[k] < S_MIN);
			if (tsum[k] > S_MAX)      tnew[k] = S_MAX[SUM_W-1:0];
			else if (tsum[k] < S_MIN) tnew[k] = S_MIN[SUM_W-1:0];
			else                      tnew[k] = tsum[k][SUM_W-1:0];
		end
		ediff  = ((SUM_W+2)'({1'b0, inv6_q}) - (SUM_W+2)'({1'b0, inv3_q})) <<< 1;
		eclamp = (ediff > E_MAX) || (ediff < E_MIN);
		if (ediff > E_MAX)      eterm = S_MAX[SUM_W-1:0];
		else if (ediff < E_MIN) eterm = S_MIN[SUM_W-1:0];
		else                    eterm = ediff[SUM_W-1:0];
		esum    = (SUM_W+1)'(sum_e_q) + (SUM_W+1)'(eterm);
		esclamp = (esum > S_MAX) || (esum < S_MIN);
		if (esum > S_MAX)      enew = S_MAX[SUM_W-1:0];
		else if (esum < S_MIN) enew = S_MIN[SUM_W-1:0];
		else                   enew = esum[SUM_W-1:0];
	end

	// Configuration, sums and sticky flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q <= CUT_RST;
			for (int k = 0; k < 3; k++) sum_q[k] <= '0;
			sum_e_q  <= '0;
			sticky_q <= 1'b0;
		end else begin
			if (cfg_we) cutoff_q <= cfg_data;
			if (cmd.load && first) begin
				for (int k = 0; k < 3; k++) sum_q[k] <= '0;
				sum_e_q  <= '0;
				sticky_q <= 1'b0;
			end
			if (cmd.flag_zero) sticky_q <= 1'b1;
			if (cmd.commit) begin
				for (int k = 0; k < 3; k++) sum_q[k] <= tnew[k];
				sum_e_q <= enew;
				if (sat_q || (|tclamp) || eclamp || esclamp) sticky_q <= 1'b1;
			end
		end
	end

	// Per-pair working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int k = 0; k < 3; k++) begin
				mag_q[k] <= dmag[k];
				neg_q[k] <= d[k][DW-1];
			end
			last_q <= last;
			sat_q  <= 1'b0;
			r2_q   <= '0;
		end
		if (div_done) begin
			if (64'(quot) > 64'(MAG_CAP)) begin
				inv_q <= MAG_CAP;
				sat_q <= 1'b1;
			end else inv_q <= MAG_W'(quot);
		end
		if (mul_done) begin
			if (cmd.op != OP_SQ_X && cmd.op != OP_SQ_Y && cmd.op != OP_SQ_Z && fm_ovf)
				sat_q <= 1'b1;
			case (cmd.op) inside
				OP_SQ_X, OP_SQ_Y, OP_SQ_Z: r2_q <= r2_q + prod[63:0];
				OP_INV2: inv2_q <= fm;
				OP_INV3: inv3_q <= fm;
				OP_INV4: inv4_q <= fm;
				OP_INV6: inv6_q <= fm;
				OP_CMAG: cmag_q <= fm;
				OP_TX:   term_q[0] <= fm;
				OP_TY:   term_q[1] <= fm;
				OP_TZ:   term_q[2] <= fm;
				default: ;
			endcase
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			acc_x            <= sum_q[0];
			acc_y            <= sum_q[1];
			acc_z            <= sum_q[2];
			potential_energy <= sum_e_q;
			saturated        <= sticky_q;
		end
	end
endmodule
`default_nettype wire

/* dv/testbench.sv */
// Self-checking testbench for lennard_jones_force_accumulator_core; drives pairs.
// Depends on design/lj_pkg.sv and the core; checks each emitted sum set against
// an in-bench predictor of the pair force and energy sums, or typed row values.
`timescale 1ns / 100ps
module testbench;
	import lj_pkg::*;

	localparam int FRAC = 16;
	localparam int PW = 24;
	localparam longint unsigned SUM_CAP = 64'h7FFF_FFFF_FFFF;
	localparam longint SUM_HI = 64'sh7FFF_FFFF_FFFF;
	localparam longint SUM_LO = -SUM_HI - 1;
	localparam longint ONE = 64'sd1 << FRAC;
	localparam int SETTLE = 400;

	typedef logic signed [PW-1:0] pos_t;

	typedef struct {
		logic signed [SUM_W-1:0] ax, ay, az, pe;
		logic sat;
	} lj_sums_t;

	typedef struct {
		pos_t own [3];
		pos_t oth [3];
		bit first, last, typed;
		lj_sums_t want;
	} pair_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic [CUT_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	pos_t own_x = '0, own_y = '0, own_z = '0;
	pos_t other_x = '0, other_y = '0, other_z = '0;
	logic first = 1'b0, last = 1'b0;
	logic out_ready = 1'b0;
	wire cfg_ready, in_ready, out_valid, saturated;
	wire signed [SUM_W-1:0] acc_x, acc_y, acc_z, potential_energy;

	lennard_jones_force_accumulator_core #(.FRAC_BITS(FRAC), .POS_WIDTH(PW)) DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.own_x(own_x), .own_y(own_y), .own_z(own_z),
		.other_x(other_x), .other_y(other_y), .other_z(other_z),
		.first(first), .last(last),
		.out_valid(out_valid), .out_ready(out_ready),
		.acc_x(acc_x), .acc_y(acc_y), .acc_z(acc_z),
		.potential_energy(potential_energy), .saturated(saturated)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Predictor state
	longint unsigned cutoff_sq = 64'd16 << FRAC;
	longint sum_x, sum_y, sum_z, sum_e;
	bit sticky;

	lj_sums_t pending_sums [$];
	pair_row_t directed_rows [$];
	int errors, pairs_sent, sums_seen, cutoffs_used;
	bit in_burst, out_burst;

	// Fixed-point product, truncated and capped at the magnitude limit
	function automatic longint unsigned qmul(input longint unsigned a, b, inout bit sat);
		logic [127:0] p;
		p = ({64'd0, a} * {64'd0, b}) >> FRAC;
		if (p > SUM_CAP) begin
			sat = 1'b1;
			return SUM_CAP;
		end
		return p[63:0];
	endfunction

	function automatic longint clamp_sum(input longint v, inout bit sat);
		if (v > SUM_HI) begin
			sat = 1'b1;
			return SUM_HI;
		end
		if (v < SUM_LO) begin
			sat = 1'b1;
			return SUM_LO;
		end
		return v;
	endfunction

	// Add one pair to the running sums; return 1 with the sums when last is set
	function automatic bit accumulate_pair(input pos_t own [3], input pos_t oth [3],
			input bit f, input bit l, output lj_sums_t res);
		longint d, t, e;
		longint unsigned mg [3];
		bit ng [3];
		bit sat, cn;
		longint unsigned r2, inv, inv2, inv3, inv4, inv6, tm, cmag;
		longint term [3];
		if (f) begin
			sum_x = 0; sum_y = 0; sum_z = 0; sum_e = 0;
			sticky = 0;
		end
		r2 = 0;
		sat = 0;
		for (int k = 0; k < 3; k++) begin
			d = longint'(own[k]) - longint'(oth[k]);
			ng[k] = d < 0;
			mg[k] = ng[k] ? longint'(-d) : d;
			if (mg[k] > (64'd1 << 31))
				mg[k] = 64'd1 << 31;
			r2 += mg[k] * mg[k];
		end
		r2 = r2 >> FRAC;
		if (r2 == 0) begin
			sticky = 1;
		end else if (r2 < cutoff_sq) begin
			inv = (64'd1 << (2 * FRAC)) / r2;
			if (inv > SUM_CAP) begin
				inv = SUM_CAP;
				sat = 1;
			end
			inv2 = qmul(inv, inv, sat);
			inv3 = qmul(inv2, inv, sat);
			inv4 = qmul(inv3, inv, sat);
			inv6 = qmul(inv3, inv3, sat);
			t = longint'(48 * inv3) - 24 * ONE;
			cn = t < 0;
			tm = cn ? -t : t;
			cmag = qmul(inv4, tm, sat);
			for (int k = 0; k < 3; k++) begin
				term[k] = longint'(qmul(mg[k], cmag, sat));
				if (ng[k] != cn)
					term[k] = -term[k];
			end
			sum_x = clamp_sum(sum_x + term[0], sat);
			sum_y = clamp_sum(sum_y + term[1], sat);
			sum_z = clamp_sum(sum_z + term[2], sat);
			e = clamp_sum(2 * (longint'(inv6) - longint'(inv3)), sat);
			sum_e = clamp_sum(sum_e + e, sat);
			if (sat)
				sticky = 1;
		end
		res.ax = sum_x[SUM_W-1:0];
		res.ay = sum_y[SUM_W-1:0];
		res.az = sum_z[SUM_W-1:0];
		res.pe = sum_e[SUM_W-1:0];
		res.sat = sticky;
		return l;
	endfunction

	task automatic add_row(input longint ox, oy, oz, px, py, pz, input bit f, l,
			input bit typed, input longint ax = 0, ay = 0, az = 0, pe = 0,
			input bit sat = 0);
		pair_row_t r;
		r.own[0] = pos_t'(ox); r.own[1] = pos_t'(oy); r.own[2] = pos_t'(oz);
		r.oth[0] = pos_t'(px); r.oth[1] = pos_t'(py); r.oth[2] = pos_t'(pz);
		r.first = f; r.last = l; r.typed = typed;
		r.want.ax = SUM_W'(ax); r.want.ay = SUM_W'(ay);
		r.want.az = SUM_W'(az); r.want.pe = SUM_W'(pe);
		r.want.sat = sat;
		directed_rows.insert(directed_rows.size(), r);
	endtask

	// Drive one pair transaction and record what it should produce
	task automatic send_pair(input pair_row_t r);
		int gap;
		lj_sums_t res;
		gap = in_burst ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		own_x <= r.own[0]; own_y <= r.own[1]; own_z <= r.own[2];
		other_x <= r.oth[0]; other_y <= r.oth[1]; other_z <= r.oth[2];
		first <= r.first; last <= r.last;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		pairs_sent++;
		if (accumulate_pair(r.own, r.oth, r.first, r.last, res)) begin
			if (r.typed)
				res = r.want;
			pending_sums.insert(pending_sums.size(), res);
		end
	endtask

	// Random pair: mostly a neighbor of the target, sometimes full-range noise
	task automatic send_random(input pos_t own [3], input bit f, l);
		pair_row_t r;
		r.typed = 0;
		r.first = f; r.last = l;
		if ($urandom_range(0, 6) == 0) begin
			for (int k = 0; k < 3; k++) begin
				r.own[k] = pos_t'($urandom);
				r.oth[k] = pos_t'($urandom);
			end
			if ($urandom_range(0, 1)) begin
				r.first = 1'($urandom_range(0, 1));
				r.last = 1'($urandom_range(0, 1));
			end
		end else begin
			for (int k = 0; k < 3; k++) begin
				r.own[k] = own[k];
				r.oth[k] = pos_t'(longint'(own[k]) +
					longint'($urandom_range(0, 4 * ONE)) - 2 * ONE);
			end
		end
		send_pair(r);
	endtask

	// Write the cutoff once the core has drained
	task automatic write_cutoff(input logic [CUT_W-1:0] v);
		@(negedge clk);
		in_valid <= 1'b0;
		wait (pending_sums.size() == 0);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		cutoff_sq = 64'(v);
		cutoffs_used++;
	endtask

	task automatic random_phase(input int n);
		pos_t own [3];
		int len, sent;
		sent = 0;
		while (sent < n) begin
			in_burst = $urandom_range(0, 3) == 0;
			len = $urandom_range(1, 8);
			for (int k = 0; k < 3; k++)
				own[k] = ($urandom_range(0, 4) == 0) ? pos_t'($urandom) :
					pos_t'($signed($urandom_range(0, 1 << 23)) - (1 << 22));
			for (int i = 0; i < len; i++)
				send_random(own, i == 0, i == len - 1);
			sent += len;
		end
	endtask

	function automatic void report(input string name, input longint want, got);
		errors++;
		if (errors <= 10)
			$display("mismatch %s: expected %0d, got %0d", name, want, got);
	endfunction

	// Check each output transaction against the oldest expectation
	always @(posedge clk) begin
		lj_sums_t w;
		if (arst_n && out_valid && out_ready) begin
			sums_seen++;
			if (pending_sums.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected output transaction");
			end else begin
				w = pending_sums.pop_front();
				if (acc_x !== w.ax) report("acc_x", longint'(w.ax), longint'(acc_x));
				if (acc_y !== w.ay) report("acc_y", longint'(w.ay), longint'(acc_y));
				if (acc_z !== w.az) report("acc_z", longint'(w.az), longint'(acc_z));
				if (potential_energy !== w.pe)
					report("energy", longint'(w.pe), longint'(potential_energy));
				if (saturated !== w.sat)
					report("saturated", longint'(w.sat), longint'(saturated));
			end
		end
	end

	// Receiver: hold out_ready low for a random stall before each transaction
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			out_burst = $urandom_range(0, 3) == 0;
			stall = out_burst ? 0 : $urandom_range(0, 19);
			if (stall > 0) begin
				@(negedge clk);
				out_ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	// Hard limit on run length
	initial begin
		#2_000_000;
		$display("FAIL lennard_jones_force_accumulator_core");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed pairs at the reset cutoff of 16.0
		add_row(ONE, 0, 0, 0, 0, 0, 1, 1, 1, 24 * ONE, 0, 0, 0, 0);
		add_row(0, -ONE, 0, 0, 0, 0, 1, 1, 1, 0, -24 * ONE, 0, 0, 0);
		add_row(12345, -7, 99, 12345, -7, 99, 1, 1, 1, 0, 0, 0, 0, 1);
		add_row(8388607, 8388607, 8388607, -8388608, -8388608, -8388608, 1, 1, 1);
		add_row(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607, 1, 1, 1);
		add_row(256, 0, 0, 0, 0, 0, 1, 1, 0);
		add_row(0, 0, 100, 0, 0, 0, 1, 0, 0);
		add_row(ONE, 0, 0, 0, 0, 0, 0, 1, 1, 24 * ONE, 0, 0, 0, 1);
		add_row(8388607, 0, 0, -8388608, 0, 0, 0, 1, 1, 24 * ONE, 0, 0, 0, 1);
		add_row(1000, 2000, 3000, 70000, -50000, 90000, 1, 0, 0);
		add_row(1000, 2000, 3000, -60000, 80000, 4000, 0, 0, 0);
		add_row(1000, 2000, 3000, 1000, 2000 + 3 * ONE / 2, 3000, 0, 0, 0);
		add_row(1000, 2000, 3000, 90000, 90000, 90000, 0, 1, 0);
		add_row(4 * ONE, 0, 0, 0, 0, 0, 1, 1, 1);
		add_row(4 * ONE - 1, 0, 0, 0, 0, 0, 1, 1, 0);
		add_row(-ONE, -ONE, -ONE, 0, 0, 0, 1, 1, 0);
		add_row(0, 0, 0, ONE / 3, ONE / 5, ONE / 7, 1, 1, 0);
		add_row(-8388608, 0, 0, -8388608 + 1000, 0, 0, 1, 1, 0);
		add_row(0, 0, 0, 0, 0, 0, 1, 1, 1, 0, 0, 0, 0, 1);
		in_burst = 0;
		foreach (directed_rows[i])
			send_pair(directed_rows[i]);
		random_phase(250);

		// Random phases at the cutoff extremes and a few settings between
		write_cutoff('0);
		random_phase(200);
		write_cutoff({CUT_W{1'b1}});
		random_phase(250);
		write_cutoff(ONE);
		random_phase(250);
		write_cutoff($urandom);
		random_phase(100);
		write_cutoff($urandom_range(ONE / 2, 12 * ONE));
		random_phase(200);
		@(negedge clk);
		in_valid <= 1'b0;

		wait (pending_sums.size() == 0);
		repeat (SETTLE) @(posedge clk);
		$display("ran %0d pairs, checked %0d sum sets over %0d cutoff settings",
			pairs_sent, sums_seen, cutoffs_used + 1);
		$display("mismatches: %0d", errors);
		if (errors == 0)
			$display("PASS lennard_jones_force_accumulator_core");
		else
			$display("FAIL lennard_jones_force_accumulator_core");
		$finish;
	end

endmodule

/* files.f */
design/lj_pkg.sv
design/lj_mul.sv
design/lj_div.sv
design/lj_ctrl.sv
design/lj_dp.sv
design/lennard_jones_force_accumulator_core.sv
dv/testbench.sv
